// File: rtl/flptw_pkg.sv
package flptw_pkg;

	// default table memory depth, in 64-bit words
	localparam int TABLE_WORDS_DEF = 8192;

	localparam int ENTRY_W = 64;
	localparam int VA_W    = 48;
	localparam int WIDX_W  = 13;
	localparam int ROOT_W  = 52;
	localparam int IDX_W   = 9;                  // entries per table: 512
	localparam int PAGE_W  = ENTRY_W - 12;       // 4 KB page number of a table pointer
	localparam int WORD_W  = PAGE_W + IDX_W;     // full word number, before range check

	// item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_XLATE = 1'b1;

	// entry flag bits
	localparam int PRESENT_BIT = 0;
	localparam int HUGE_BIT    = 7;

	typedef struct packed {
		logic                 kind;
		logic [VA_W-1:0]      virt_addr;
		logic [WIDX_W-1:0]    word_index;
		logic [ENTRY_W-1:0]   word_data;
	} item_t;

	typedef struct packed {
		logic [ENTRY_W-1:0]   phys_addr;
		logic                 mapped;
		logic                 huge_page;
		logic                 out_of_range;
	} result_t;

endpackage

// File: rtl/flptw_ram.sv
module flptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/four_level_page_table_walk.sv
// Four-level page table walker (x86-64 layout: 4 KB pages, 2 MB huge pages at
// the directory level) over a local table memory of TABLE_WORDS 64-bit words.
// An item is taken when start is high and busy is low. kind 0 writes one table
// word (indexes at or beyond TABLE_WORDS are dropped); kind 1 translates
// virt_addr starting at the table that root_table_address points to. Every item
// gives exactly one result beat, shown for one cycle with done high; the
// receiver cannot stall it, so it must take every done beat. A write, or a
// root table out of range, leaves busy low; a walk keeps busy high while it
// reads one table level after another, until a 4 KB leaf, a 2 MB page, an
// entry that is not present or a pointer out of range ends it. The walk's
// length is set by the single registered read port of the table memory: each
// level's entry must come back before the next level's address is known. The
// done beat overlaps the first cycle of the next item.
// A table pointer keeps every entry bit above bit 11 (flags included), and a
// pointer whose word lies at or beyond TABLE_WORDS ends the walk with
// out_of_range. Table entries must be written before a walk reads them; a
// never-written word reads back as anything. root_table_address is written over
// the cfg channel (always ready) and must only change while the block is idle.
module four_level_page_table_walk #(
	parameter int TABLE_WORDS = flptw_pkg::TABLE_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// command side
	input  logic                         start,
	output logic                         busy,
	input  flptw_pkg::item_t             item,
	// result side
	output logic                         done,
	output flptw_pkg::result_t           result,
	// root register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [flptw_pkg::ROOT_W-1:0] cfg_data
);

	import flptw_pkg::*;

	localparam int AW = $clog2(TABLE_WORDS);
	localparam logic [WORD_W-1:0] TW_WORDS = WORD_W'(TABLE_WORDS);

	// walk levels
	localparam logic [1:0] LVL_TOP  = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_DIR  = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t               state_q, state_d;
	logic [1:0]           lvl_q, lvl_d;
	logic [VA_W-1:0]      va_q;
	logic [ROOT_W-1:0]    root_q;
	logic                 done_q;
	result_t              result_q, res_d;
	logic                 res_load;

	// table memory port
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [ENTRY_W-1:0]   rd_data;

	logic [WORD_W-1:0]    wr_word;
	logic [WORD_W-1:0]    root_word;
	logic [WORD_W-1:0]    walk_word;
	logic [IDX_W-1:0]     next_idx;
	logic [ENTRY_W-1:0]   phys_2m;
	logic [ENTRY_W-1:0]   phys_4k;

	flptw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_WORDS)
	) u_tbl (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (item.word_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign result    = result_q;

	// word numbers: table page number, then the 9-bit index within the table
	assign wr_word   = WORD_W'(item.word_index);
	assign root_word = {PAGE_W'(root_q[ROOT_W-1:12]), item.virt_addr[47:39]};
	assign walk_word = {rd_data[ENTRY_W-1:12], next_idx};
	assign wr_addr   = wr_word[AW-1:0];

	// index field of the level about to be read
	always_comb begin
		case (lvl_q)
			LVL_TOP:  next_idx = va_q[38:30];
			LVL_PDPT: next_idx = va_q[29:21];
			default:  next_idx = va_q[20:12];
		endcase
	end

	assign phys_2m = {rd_data[ENTRY_W-1:21], 21'b0} + ENTRY_W'(va_q[20:0]);
	assign phys_4k = {rd_data[ENTRY_W-1:12], 12'b0} + ENTRY_W'(va_q[11:0]);

	// sequencer: one address check and one table read per cycle
	always_comb begin
		state_d  = state_q;
		lvl_d    = lvl_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = root_word[AW-1:0];
		res_d    = '0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.kind == KIND_WRITE) begin
						wr_en    = (wr_word < TW_WORDS);
						res_load = 1'b1;
					end else if (root_word >= TW_WORDS) begin
						res_d.out_of_range = 1'b1;
						res_load           = 1'b1;
					end else begin
						rd_en   = 1'b1;
						lvl_d   = LVL_TOP;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				rd_addr = walk_word[AW-1:0];
				if (!rd_data[PRESENT_BIT]) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end else if (lvl_q == LVL_DIR && rd_data[HUGE_BIT]) begin
					res_d.phys_addr = phys_2m;
					res_d.mapped    = 1'b1;
					res_d.huge_page = 1'b1;
					res_load        = 1'b1;
					state_d         = ST_IDLE;
				end else if (lvl_q == LVL_PT) begin
					res_d.phys_addr = phys_4k;
					res_d.mapped    = 1'b1;
					res_load        = 1'b1;
					state_d         = ST_IDLE;
				end else if (walk_word >= TW_WORDS) begin
					res_d.out_of_range = 1'b1;
					res_load           = 1'b1;
					state_d            = ST_IDLE;
				end else begin
					rd_en = 1'b1;
					lvl_d = lvl_q + 2'd1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= LVL_TOP;
			root_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			done_q  <= res_load;
			if (cfg_valid && cfg_ready) begin
				root_q <= cfg_data;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			va_q <= item.virt_addr;
		end
		if (res_load) begin
			result_q <= res_d;
		end
	end

endmodule

// File: verif/tb_four_level_page_table_walk.sv
module tb_four_level_page_table_walk;
	timeunit 1ns;
	timeprecision 1ps;

	import flptw_pkg::*;

	localparam int TABLE_WORDS  = TABLE_WORDS_DEF;
	localparam int TABLE_PAGES  = TABLE_WORDS / 512;
	// quiet cycles before we call it a hang; far longer than any walk or any
	// sender gap at 77% idle
	localparam int STALL_LIMIT  = 2000;
	// settle time after the last done beat
	localparam int SETTLE_CYCLES = 8;

	// ------------------------------------------------------------------
	// Scoreboard: shadow copy of the table memory and root register, a
	// software walk, and the in-order queue of predicted result beats.
	// ------------------------------------------------------------------
	class walk_scoreboard;
		logic [ENTRY_W-1:0] table_mem [TABLE_WORDS];
		bit                 written   [TABLE_WORDS];
		logic [ROOT_W-1:0]  root;
		result_t            outcome_q [$];
		int unsigned        mismatches;

		function new();
			root = '0;
			mismatches = 0;
		endfunction

		function void set_root(logic [ROOT_W-1:0] value);
			root = value;
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		// Walk the shadow tables. need is the word index of the first
		// never-written word the walk would read, or -1 if there is none.
		function result_t walk(logic [VA_W-1:0] va, output int need);
			result_t            r;
			logic [ENTRY_W-1:0] base;
			logic [ENTRY_W-1:0] e;
			logic [WORD_W-1:0]  word;
			int                 lvl;
			r = '0;
			need = -1;
			base = {{(ENTRY_W-ROOT_W){1'b0}}, root};
			for (lvl = 0; lvl < 4; lvl++) begin
				// page number keeps all bits above 11, flags included
				word = {base[ENTRY_W-1:12], va[VA_W-1-9*lvl -: IDX_W]};
				if (word >= TABLE_WORDS) begin
					r.out_of_range = 1'b1;
					return r;
				end
				if (!written[word]) begin
					need = int'(word);
					return r;
				end
				e = table_mem[word];
				if (!e[PRESENT_BIT])
					return r;
				// huge bit only counts at the directory level
				if (lvl == 2 && e[HUGE_BIT]) begin
					r.phys_addr = {e[ENTRY_W-1:21], 21'b0} + ENTRY_W'(va[20:0]);
					r.mapped = 1'b1;
					r.huge_page = 1'b1;
					return r;
				end
				if (lvl == 3) begin
					r.phys_addr = {e[ENTRY_W-1:12], 12'b0} + ENTRY_W'(va[11:0]);
					r.mapped = 1'b1;
					return r;
				end
				base = e;
			end
			return r;
		endfunction

		function void note_item(item_t it);
			int need;
			if (it.kind == KIND_WRITE) begin
				if (it.word_index < TABLE_WORDS) begin
					table_mem[it.word_index] = it.word_data;
					written[it.word_index] = 1'b1;
				end
				outcome_q.push_back('0);
			end else begin
				outcome_q.push_back(walk(it.virt_addr, need));
			end
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: phys %h mapped %b huge %b oor %b",
						got.phys_addr, got.mapped, got.huge_page, got.out_of_range);
				return;
			end
			exp = outcome_q.pop_front();
			if (got.phys_addr !== exp.phys_addr || got.mapped !== exp.mapped ||
					got.huge_page !== exp.huge_page ||
					got.out_of_range !== exp.out_of_range) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: exp phys %h mapped %b huge %b oor %b, ",
						"got phys %h mapped %b huge %b oor %b"},
						exp.phys_addr, exp.mapped, exp.huge_page, exp.out_of_range,
						got.phys_addr, got.mapped, got.huge_page, got.out_of_range);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------
	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	item_t             item;
	logic              done;
	result_t           result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [ROOT_W-1:0] cfg_data;

	four_level_page_table_walk #(
		.TABLE_WORDS(TABLE_WORDS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	walk_scoreboard sb = new();

	int unsigned items_sent = 0;
	int unsigned idle_pct = 0;     // chance per cycle that the sender holds off
	int unsigned quiet_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Monitor: everything sampled at the rising edge; inputs only move on
	// the falling edge, so there is no ordering race with the DUT.
	// Result beat is checked before the new item is noted: a done beat
	// always belongs to an older item.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_item(item);
			if (cfg_valid && cfg_ready)
				sb.set_root(cfg_data);
		end
	end

	// watchdog: any accepted beat on any channel resets the count
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver tasks. All are entered and left on a falling edge. issue_item
	// leaves start high after the accept so back-to-back beats need no
	// second assignment in one step; anything that pauses the stream must
	// drop start itself (quiesce does).
	// ------------------------------------------------------------------
	task automatic issue_item(input item_t it);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_word(input logic [WIDX_W-1:0] idx, input logic [ENTRY_W-1:0] data);
		item_t it;
		it.kind = KIND_WRITE;
		it.virt_addr = VA_W'({$urandom, $urandom});  // ignored on writes
		it.word_index = idx;
		it.word_data = data;
		issue_item(it);
	endtask

	// Random table entry: mostly a pointer into the table memory, some with
	// a high flag bit kept in the pointer, some fully random (out of range
	// as a pointer, a wide frame as a leaf). Present most of the time.
	function automatic logic [ENTRY_W-1:0] rand_entry();
		logic [ENTRY_W-1:0] e;
		int unsigned        pick;
		e = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 82)
			e[ENTRY_W-1:12] = PAGE_W'($urandom_range(0, TABLE_PAGES - 1));
		else if (pick < 88)
			e[ENTRY_W-1:12] = {1'b1, (PAGE_W-1)'($urandom_range(0, TABLE_PAGES - 1))};
		e[PRESENT_BIT] = ($urandom_range(0, 99) < 90);
		e[HUGE_BIT] = ($urandom_range(0, 99) < 30);
		return e;
	endfunction

	// Translate va. Any table word the walk would touch that was never
	// written gets filled first with a random entry, so every read lands on
	// defined data and the walk goes as deep as the entries allow.
	task automatic translate(input logic [VA_W-1:0] va);
		int      need;
		item_t   it;
		void'(sb.walk(va, need));
		while (need >= 0) begin
			write_word(WIDX_W'(need), rand_entry());
			void'(sb.walk(va, need));
		end
		it.kind = KIND_XLATE;
		it.virt_addr = va;
		it.word_index = WIDX_W'($urandom);      // ignored on translations
		it.word_data = {$urandom, $urandom};
		issue_item(it);
	endtask

	// drain every outstanding beat, then let the walker settle
	task automatic quiesce();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_root(input logic [ROOT_W-1:0] value);
		quiesce();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int                 seg;
		int                 lvl;
		int unsigned        seg_end;
		logic [ROOT_W-1:0]  root_val;
		logic [VA_W-1:0]    va;

		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, root at page 0, back to back
		write_root('0);
		write_word(13'd0, 64'h0);                       // top entry not present
		translate(48'h0000_0000_0000);
		write_word(13'd0, 64'h0000_0000_0000_1001);     // top 0 -> page 1
		write_word(13'd512, 64'h0000_0000_0000_2081);   // huge bit ignored above dir
		write_word(13'd1024, 64'h0000_0000_0000_3001);  // dir 0 -> page 3
		write_word(13'd1536, 64'hFFFF_FFFF_FFFF_FFFF);  // leaf, every bit set
		translate(48'h0000_0000_0FFF);                  // full 4 KB walk, max offset
		write_word(13'd1537, 64'hFFFF_FFFF_FFFF_FFFE);  // leaf not present
		translate(48'h0000_0000_1000);
		write_word(13'd1025, 64'hFFFF_FFFF_FFE0_0081);  // 2 MB page, top frame
		translate(48'h0000_003F_FFFF);
		write_word(13'd1026, 64'h0);                    // directory not present
		translate(48'h0000_0040_0000);
		write_word(13'd1, 64'h0000_0000_0001_0001);     // pointer just past memory
		translate(48'h0080_0000_0000);
		write_word(13'd2, 64'h8000_0000_0000_1001);     // flag bit 63 stays in pointer
		translate(48'h0100_0000_0000);
		write_word(13'd8191, 64'hFFFF_FFFF_FFFF_FFFF);
		write_word(13'd8190, 64'h0);
		write_root({ROOT_W{1'b1}});                     // root itself out of range
		translate({VA_W{1'b1}});
		write_root(ROOT_W'(52'hF_FFF));                 // last page, low bits ignored
		translate({VA_W{1'b1}});

		// random part: six segments, each behind its own root setting;
		// sender idles 27%, then 77%, then not at all
		for (seg = 0; seg < 6; seg++) begin
			idle_pct = (seg < 2) ? 27 : (seg < 4) ? 77 : 0;
			case (seg)
				0: root_val = '0;
				2: root_val = ROOT_W'(52'hF_FFF);
				3: root_val = {ROOT_W{1'b1}};
				default: root_val = (ROOT_W'($urandom_range(1, TABLE_PAGES - 2)) << 12) |
					ROOT_W'($urandom_range(0, 4095));
			endcase
			write_root(root_val);
			// the all-ones root only yields out-of-range walks: keep it short
			seg_end = items_sent + ((seg == 3) ? 20 : 90);
			while (items_sent < seg_end) begin
				if ($urandom_range(0, 99) < 20) begin
					// stray write anywhere, sometimes with extreme data
					case ($urandom_range(0, 3))
						0: write_word(WIDX_W'($urandom), '0);
						1: write_word(WIDX_W'($urandom), '1);
						default: write_word(WIDX_W'($urandom), {$urandom, $urandom});
					endcase
				end else begin
					// bias index fields toward a few entries so walks share tables
					va = VA_W'({$urandom, $urandom});
					for (lvl = 0; lvl < 4; lvl++)
						if ($urandom_range(0, 1))
							va[VA_W-1-9*lvl -: IDX_W] = IDX_W'($urandom_range(0, 3));
					translate(va);
				end
			end
		end

		quiesce();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
